// ===== sv/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants of the depth to point cloud block: register
// indexes, sequencer states and the control word of the multiply-accumulate.
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Operand width of the shared multiplier and width of its accumulator.
	localparam int OP_W  = 33;
	localparam int ACC_W = 88;
	// Camera coordinates are signed Q.24 clamped to 46 magnitude bits.
	localparam int CAM_W = 47;

	localparam int DEPTH_W = 24;
	localparam int POS_W   = 12;
	localparam int POINT_W = 32;
	localparam int CFG_W   = 64;
	localparam int DIM_W   = 13;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_FAR_LIMIT      = 3'd2,
		REG_INV_FOCAL      = 3'd3,
		REG_PRINCIPAL_SKEW = 3'd4,
		REG_POSE_ROW0      = 3'd5,
		REG_POSE_ROW1      = 3'd6,
		REG_POSE_ROW2      = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DY,
		ST_YLO,
		ST_YHI,
		ST_YRND,
		ST_SLO,
		ST_SHI,
		ST_SRND,
		ST_DX,
		ST_XLO,
		ST_XHI,
		ST_XRND,
		ST_P0LO,
		ST_P0HI,
		ST_P1LO,
		ST_P1HI,
		ST_P2LO,
		ST_P2HI,
		ST_PT,
		ST_FIN,
		ST_OUT
	} st_t;

	typedef enum logic [1:0] {
		BASE_ZERO,
		BASE_ACC,
		BASE_EXT
	} base_sel_t;

	typedef struct packed {
		logic      en;
		base_sel_t base;
		logic      sh32;
	} mac_ctrl_t;

endpackage

// ===== sv/depth_to_point_cloud.sv =====
// ----------------------------------------------------------------------------
// depth_to_point_cloud
// Back-projects raster depth samples through a pinhole camera with skew and
// maps each point through the inverse rigid pose into saturated Q16.16.
// A sample is taken only while s_tready is high. A sample at or beyond
// far_limit gives no point, still advances the raster position, and the
// block is ready again in the next cycle. Any other sample keeps the block
// busy until its point has gone to the output register, so the block takes
// no new sample while one is in work: one 33 x 33 bit multiplier with an
// 88-bit accumulator carries all 29 multiply steps (camera y, skew, camera
// x, three pose rows with translation), with rounding and clamping in
// between. The finished point waits in an output register, and the block
// goes on to the next sample once that register is free.
// ----------------------------------------------------------------------------
module depth_to_point_cloud import dpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DEPTH_W-1:0]   s_tdata,   // depth_sample[23:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// point_x[31:0], point_y[63:32], point_z[95:64], pixel_col[107:96],
	// pixel_row[119:108]
	output logic [119:0]         m_tdata,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	localparam logic signed [ACC_W-1:0]   HALF32 = ACC_W'(1) <<< 31;
	localparam logic signed [ACC_W-1:0]   HALF22 = ACC_W'(1) <<< 21;
	localparam logic signed [ACC_W-1:0]   HALF8  = ACC_W'(1) <<< 7;
	localparam logic signed [ACC_W-33:0]  CAM_MAX = (ACC_W-32)'((64'd1 << 46) - 64'd1);
	localparam logic signed [ACC_W-23:0]  PT_MAX = (ACC_W-22)'(32'h7fffffff);
	localparam logic signed [ACC_W-23:0]  PT_MIN = -(ACC_W-22)'(33'h080000000);
	localparam logic signed [OP_W-1:0]    T_SCALE = OP_W'(1) <<< 30;

	// Configuration registers.
	logic [DIM_W-1:0]   image_width_q;
	logic [DIM_W-1:0]   image_height_q;
	logic [DEPTH_W-1:0] far_limit_q;
	logic [CFG_W-1:0]   inv_focal_q;
	logic [CFG_W-1:0]   principal_skew_q;
	logic [CFG_W-1:0]   pose0_q;
	logic [CFG_W-1:0]   pose1_q;
	logic [CFG_W-1:0]   pose2_q;

	// Control state.
	st_t             state_q;
	st_t             state_d;
	logic [1:0]      idx_q;
	logic [POS_W-1:0] col_count_q;
	logic [POS_W-1:0] row_count_q;
	logic            m_tvalid_q;

	// Datapath registers.
	logic [DEPTH_W-1:0]        d_q;
	logic [POS_W-1:0]          pcol_q;
	logic [POS_W-1:0]          prow_q;
	logic signed [63:0]        tmp_q;
	logic signed [CAM_W-1:0]   yc_q;
	logic signed [CAM_W-1:0]   xc_q;
	logic [POINT_W-1:0]        res_q [3];
	logic [POINT_W-1:0]        out_x_q;
	logic [POINT_W-1:0]        out_y_q;
	logic [POINT_W-1:0]        out_z_q;
	logic [POS_W-1:0]          out_col_q;
	logic [POS_W-1:0]          out_row_q;

	// Sequencer outputs.
	mac_ctrl_t               mac_ctrl;
	logic signed [OP_W-1:0]  op_a;
	logic signed [OP_W-1:0]  op_b;
	logic                    tmp_ld;
	logic                    sy_ld;
	logic                    yc_ld;
	logic                    xc_ld;
	logic                    res_shift;
	logic                    out_load;

	logic signed [ACC_W-1:0] acc;
	logic                    accept;
	logic                    dropped;
	logic [DIM_W-1:0]        next_col;
	logic [DIM_W-1:0]        next_row;
	logic                    col_wrap;
	logic                    row_wrap;
	logic signed [25:0]      dy;
	logic signed [25:0]      ndx;
	logic signed [CAM_W-1:0] cam_z;
	logic [CFG_W-1:0]        pose_sel;
	logic signed [63:0]      sy;
	logic [POINT_W-1:0]      row_result;

	function automatic logic signed [CAM_W-1:0] rnd32_clamp(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0]  t;
		logic signed [ACC_W-33:0] q;
		logic signed [CAM_W-1:0]  r;
		t = v + (v[ACC_W-1] ? (HALF32 - ACC_W'(1)) : HALF32);
		q = t[ACC_W-1:32];
		if (q > CAM_MAX) begin
			r = CAM_MAX[CAM_W-1:0];
		end else if (q < -CAM_MAX) begin
			r = -CAM_MAX[CAM_W-1:0];
		end else begin
			r = q[CAM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [POINT_W-1:0] rnd22_sat(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0]  t;
		logic signed [ACC_W-23:0] q;
		logic [POINT_W-1:0]       r;
		t = v + (v[ACC_W-1] ? (HALF22 - ACC_W'(1)) : HALF22);
		q = t[ACC_W-1:22];
		if (q > PT_MAX) begin
			r = PT_MAX[POINT_W-1:0];
		end else if (q < PT_MIN) begin
			r = PT_MIN[POINT_W-1:0];
		end else begin
			r = q[POINT_W-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= DIM_W'(640);
			image_height_q   <= DIM_W'(480);
			far_limit_q      <= '1;
			inv_focal_q      <= '0;
			principal_skew_q <= '0;
			pose0_q          <= CFG_W'(64'd16384);
			pose1_q          <= CFG_W'(64'd16384 << 16);
			pose2_q          <= CFG_W'(64'd16384 << 32);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_IMAGE_WIDTH:    image_width_q    <= wr_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q   <= wr_data[DIM_W-1:0];
				REG_FAR_LIMIT:      far_limit_q      <= wr_data[DEPTH_W-1:0];
				REG_INV_FOCAL:      inv_focal_q      <= wr_data;
				REG_PRINCIPAL_SKEW: principal_skew_q <= wr_data;
				REG_POSE_ROW0:      pose0_q          <= wr_data;
				REG_POSE_ROW1:      pose1_q          <= wr_data;
				REG_POSE_ROW2:      pose2_q          <= wr_data;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Raster position
	// ------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign dropped  = (s_tdata >= far_limit_q);

	assign next_col = {1'b0, col_count_q} + DIM_W'(1);
	assign next_row = {1'b0, row_count_q} + DIM_W'(1);
	// A zero width or height compares as always reached, which acts as one.
	assign col_wrap = next_col[POS_W] || (next_col >= image_width_q)
		|| (int'(next_col) >= MAX_WIDTH);
	assign row_wrap = next_row[POS_W] || (next_row >= image_height_q)
		|| (int'(next_row) >= MAX_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_count_q <= '0;
				row_count_q <= row_wrap ? '0 : next_row[POS_W-1:0];
			end else begin
				col_count_q <= next_col[POS_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && !dropped) state_d = ST_DY;
			ST_DY:    state_d = ST_YLO;
			ST_YLO:   state_d = ST_YHI;
			ST_YHI:   state_d = ST_YRND;
			ST_YRND:  state_d = ST_SLO;
			ST_SLO:   state_d = ST_SHI;
			ST_SHI:   state_d = ST_SRND;
			ST_SRND:  state_d = ST_DX;
			ST_DX:    state_d = ST_XLO;
			ST_XLO:   state_d = ST_XHI;
			ST_XHI:   state_d = ST_XRND;
			ST_XRND:  state_d = ST_P0LO;
			ST_P0LO:  state_d = ST_P0HI;
			ST_P0HI:  state_d = ST_P1LO;
			ST_P1LO:  state_d = ST_P1HI;
			ST_P1HI:  state_d = ST_P2LO;
			ST_P2LO:  state_d = ST_P2HI;
			ST_P2HI:  state_d = ST_PT;
			ST_PT:    state_d = (idx_q == 2'd2) ? ST_FIN : ST_P0LO;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PT) begin
				idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Operand sources.
	assign dy    = $signed({2'b00, principal_skew_q[47:24]})
		- $signed({2'b00, prow_q, 12'h000});
	// The x numerator is formed negated, which absorbs the sign of camera x.
	assign ndx   = $signed({2'b00, pcol_q, 12'h000})
		- $signed({2'b00, principal_skew_q[23:0]});
	assign cam_z = -$signed({11'b0, d_q, 12'h000});

	always_comb begin
		case (idx_q)
			2'd0:    pose_sel = pose0_q;
			2'd1:    pose_sel = pose1_q;
			default: pose_sel = pose2_q;
		endcase
	end

	always_comb begin
		mac_ctrl  = '{en: 1'b0, base: BASE_ZERO, sh32: 1'b0};
		op_a      = '0;
		op_b      = '0;
		tmp_ld    = 1'b0;
		sy_ld     = 1'b0;
		yc_ld     = 1'b0;
		xc_ld     = 1'b0;
		res_shift = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_DY: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ZERO, sh32: 1'b0};
				op_a     = {{7{dy[25]}}, dy};
				op_b     = {9'b0, d_q};
			end
			ST_YLO, ST_XLO: begin
				tmp_ld   = 1'b1;
				mac_ctrl = '{en: 1'b1, base: BASE_ZERO, sh32: 1'b0};
				op_a     = {1'b0, acc[31:0]};
				op_b     = (state_q == ST_YLO) ? {1'b0, inv_focal_q[31:0]}
					: {1'b0, inv_focal_q[63:32]};
			end
			ST_YHI, ST_XHI: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b1};
				op_a     = {tmp_q[63], tmp_q[63:32]};
				op_b     = (state_q == ST_YHI) ? {1'b0, inv_focal_q[31:0]}
					: {1'b0, inv_focal_q[63:32]};
			end
			ST_YRND: yc_ld = 1'b1;
			ST_SLO: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ZERO, sh32: 1'b0};
				op_a     = {1'b0, yc_q[31:0]};
				op_b     = {{17{principal_skew_q[63]}}, principal_skew_q[63:48]};
			end
			ST_SHI: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b1};
				op_a     = {{18{yc_q[CAM_W-1]}}, yc_q[CAM_W-1:32]};
				op_b     = {{17{principal_skew_q[63]}}, principal_skew_q[63:48]};
			end
			ST_SRND: sy_ld = 1'b1;
			ST_DX: begin
				mac_ctrl = '{en: 1'b1, base: BASE_EXT, sh32: 1'b0};
				op_a     = {{7{ndx[25]}}, ndx};
				op_b     = {9'b0, d_q};
			end
			ST_XRND: xc_ld = 1'b1;
			ST_P0LO: begin
				// The previous pose row is still in the accumulator here.
				res_shift = (idx_q != 2'd0);
				mac_ctrl  = '{en: 1'b1, base: BASE_ZERO, sh32: 1'b0};
				op_a      = {1'b0, xc_q[31:0]};
				op_b      = {{17{pose_sel[15]}}, pose_sel[15:0]};
			end
			ST_P0HI: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b1};
				op_a     = {{18{xc_q[CAM_W-1]}}, xc_q[CAM_W-1:32]};
				op_b     = {{17{pose_sel[15]}}, pose_sel[15:0]};
			end
			ST_P1LO: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b0};
				op_a     = {1'b0, yc_q[31:0]};
				op_b     = {{17{pose_sel[31]}}, pose_sel[31:16]};
			end
			ST_P1HI: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b1};
				op_a     = {{18{yc_q[CAM_W-1]}}, yc_q[CAM_W-1:32]};
				op_b     = {{17{pose_sel[31]}}, pose_sel[31:16]};
			end
			ST_P2LO: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b0};
				op_a     = {1'b0, cam_z[31:0]};
				op_b     = {{17{pose_sel[47]}}, pose_sel[47:32]};
			end
			ST_P2HI: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b1};
				op_a     = {{18{cam_z[CAM_W-1]}}, cam_z[CAM_W-1:32]};
				op_b     = {{17{pose_sel[47]}}, pose_sel[47:32]};
			end
			ST_PT: begin
				mac_ctrl = '{en: 1'b1, base: BASE_ACC, sh32: 1'b0};
				op_a     = {{17{pose_sel[63]}}, pose_sel[63:48]};
				op_b     = T_SCALE;
			end
			ST_FIN: res_shift = 1'b1;
			ST_OUT: out_load = !m_tvalid_q || m_tready;
		endcase
	end

	dpc_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.ext  (tmp_q),
		.acc  (acc)
	);

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_comb begin
		logic signed [ACC_W-1:0] t;
		t  = acc + (acc[ACC_W-1] ? (HALF8 - ACC_W'(1)) : HALF8);
		sy = t[71:8];
	end

	assign row_result = rnd22_sat(acc);

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q    <= s_tdata;
			pcol_q <= col_count_q;
			prow_q <= row_count_q;
		end
		if (tmp_ld) begin
			tmp_q <= acc[63:0];
		end else if (sy_ld) begin
			tmp_q <= sy;
		end
		if (yc_ld) begin
			yc_q <= rnd32_clamp(acc);
		end
		if (xc_ld) begin
			xc_q <= rnd32_clamp(acc);
		end
		if (res_shift) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
			res_q[2] <= row_result;
		end
		if (out_load) begin
			out_x_q   <= res_q[0];
			out_y_q   <= res_q[1];
			out_z_q   <= res_q[2];
			out_col_q <= pcol_q;
			out_row_q <= prow_q;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_row_q, out_col_q, out_z_q, out_y_q, out_x_q};

`ifndef ASSERT_OFF
	// A kept sample starts the camera y multiply right away.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !dropped) |=> (state_q == ST_DY))
		else $error("kept item did not start the sequencer");

	// The pose row counter is back at zero whenever the block is idle.
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == 2'd0))
		else $error("pose row counter not cleared at idle");

	// A new point is only presented after the handoff state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("point presented outside the handoff state");

	// The clamp keeps camera y off the most negative code.
	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLO) |-> (yc_q != {1'b1, {(CAM_W-1){1'b0}}}))
		else $error("camera y escaped the clamp");

	// The last pose row is rounded exactly once before handoff.
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> $past(state_q == ST_PT) && (idx_q == 2'd0))
		else $error("final row rounded out of order");
`endif

endmodule

// ===== sv/dpc_mac.sv =====
// ----------------------------------------------------------------------------
// dpc_mac
// Shared signed multiply-accumulate unit: acc = base + (a * b) << {0 | 32}.
// ----------------------------------------------------------------------------
module dpc_mac import dpc_pkg::*; (
	input  logic                    clk,
	input  mac_ctrl_t               ctrl,
	input  logic signed [OP_W-1:0]  op_a,
	input  logic signed [OP_W-1:0]  op_b,
	input  logic signed [63:0]      ext,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*OP_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	assign prod     = op_a * op_b;
	assign prod_ext = {{(ACC_W-2*OP_W){prod[2*OP_W-1]}}, prod};

	// The high partial products stay well inside the accumulator, so the
	// bits shifted out on the left are only sign copies.
	assign addend = ctrl.sh32 ? (prod_ext <<< 32) : prod_ext;

	always_comb begin
		unique case (ctrl.base)
			BASE_ZERO: base = '0;
			BASE_ACC:  base = acc_q;
			BASE_EXT:  base = {{(ACC_W-64){ext[63]}}, ext};
			default:   base = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ===== verif/tb_depth_to_point_cloud.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_to_point_cloud
// Self-checking bench for the depth to point cloud block. Raster depth
// samples are streamed in while a scoreboard tracks the pixel position and
// back-projects every kept sample through the camera and pose. Every point
// that leaves the block is then compared with the oldest prediction. Both
// stream sides idle at random, and the output is once held off long enough
// to back up the input.
// ----------------------------------------------------------------------------
module tb_depth_to_point_cloud;
	import dpc_pkg::*;

	localparam int LONG_HOLD     = 600;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 244;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'hFFFFFF;
	localparam logic [CFG_W-1:0]   ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint CAM_MAX = (64'sd1 <<< 46) - 1;
	localparam longint SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SAT_MIN = -SAT_MAX - 1;

	typedef struct packed {
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic [POINT_W-1:0] z;
		logic [POINT_W-1:0] y;
		logic [POINT_W-1:0] x;
	} point_t;

	class point_scoreboard;
		logic [DIM_W-1:0]   width, height;
		logic [DEPTH_W-1:0] far;
		logic [CFG_W-1:0]   inv_focal, principal_skew;
		logic [CFG_W-1:0]   pose[3];
		logic [POS_W-1:0]   col, row;
		point_t             points_due[$];
		int                 mismatches;

		function new();
			width = 13'd640;
			height = 13'd480;
			far = DEPTH_MAX;
			inv_focal = '0;
			principal_skew = '0;
			pose[0] = 64'd16384;
			pose[1] = 64'd16384 << 16;
			pose[2] = 64'd16384 << 32;
			col = '0;
			row = '0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH:    width = value[DIM_W-1:0];
				REG_IMAGE_HEIGHT:   height = value[DIM_W-1:0];
				REG_FAR_LIMIT:      far = value[DEPTH_W-1:0];
				REG_INV_FOCAL:      inv_focal = value;
				REG_PRINCIPAL_SKEW: principal_skew = value;
				REG_POSE_ROW0:      pose[0] = value;
				REG_POSE_ROW1:      pose[1] = value;
				REG_POSE_ROW2:      pose[2] = value;
				default: ;
			endcase
		endfunction

		function longint unsigned magnitude(longint v);
			longint unsigned m;
			m = v;
			if (v < 0)
				m = 64'd0 - m;
			return m;
		endfunction

		function longint apply_sign(longint unsigned m, bit neg);
			longint s;
			s = m;
			return neg ? -s : s;
		endfunction

		// Divide by 2^s, rounding to nearest with ties away from zero.
		function longint round_shift(longint v, int s);
			longint unsigned m;
			m = magnitude(v);
			m = (m + (64'd1 << (s - 1))) >> s;
			return apply_sign(m, v < 0);
		endfunction

		// Scale by an unsigned Q0.32 reciprocal, split so that nothing overflows.
		function longint scale_q32(longint v, logic [31:0] r);
			longint unsigned m, hi, lo, r64, res;
			m = magnitude(v);
			hi = m >> 32;
			lo = m & 64'hFFFF_FFFF;
			r64 = 64'(r);
			res = hi * r64 + ((lo * r64 + 64'h8000_0000) >> 32);
			return apply_sign(res, v < 0);
		endfunction

		function longint clamp_cam(longint v);
			if (v > CAM_MAX)
				return CAM_MAX;
			if (v < -CAM_MAX)
				return -CAM_MAX;
			return v;
		endfunction

		function logic [POINT_W-1:0] sat32(longint v);
			if (v > SAT_MAX)
				return 32'h7FFF_FFFF;
			if (v < SAT_MIN)
				return 32'h8000_0000;
			return v[31:0];
		endfunction

		function longint sext16(logic [15:0] v);
			return longint'($signed(v));
		endfunction

		function point_t project_point(logic [DEPTH_W-1:0] d, logic [POS_W-1:0] c,
				logic [POS_W-1:0] r);
			longint depth, cx, cy, pc, pr, dx, dy, yc, sy, num, acc;
			longint cam[3];
			logic [POINT_W-1:0] axis[3];
			point_t p;
			int i;
			depth = longint'(d);
			cx = longint'(principal_skew[23:0]);
			cy = longint'(principal_skew[47:24]);
			pc = longint'(c);
			pr = longint'(r);
			dx = cx - pc * 4096;
			dy = cy - pr * 4096;
			yc = clamp_cam(scale_q32(dy * depth, inv_focal[31:0]));
			sy = round_shift(sext16(principal_skew[63:48]) * yc, 8);
			num = dx * depth - sy;
			cam[0] = clamp_cam(-scale_q32(num, inv_focal[63:32]));
			cam[1] = yc;
			cam[2] = -(depth << 12);
			// Rotation is Q2.14 and the camera point Q.24, so the sum is Q.38.
			for (i = 0; i < 3; i++) begin
				acc = sext16(pose[i][15:0]) * cam[0] + sext16(pose[i][31:16]) * cam[1]
					+ sext16(pose[i][47:32]) * cam[2]
					+ sext16(pose[i][63:48]) * (64'sd1 <<< 30);
				axis[i] = sat32(round_shift(acc, 22));
			end
			p.x = axis[0];
			p.y = axis[1];
			p.z = axis[2];
			p.col = c;
			p.row = r;
			return p;
		endfunction

		function void note_input(logic [DEPTH_W-1:0] d);
			logic [POS_W-1:0] c, r;
			int nc, nr;
			c = col;
			r = row;
			nc = int'(col) + 1;
			if (nc >= int'(width) || nc >= MAX_WIDTH || nc > 4095) begin
				nr = int'(row) + 1;
				col = '0;
				if (nr >= int'(height) || nr >= MAX_HEIGHT || nr > 4095)
					row = '0;
				else
					row = nr[POS_W-1:0];
			end else begin
				col = nc[POS_W-1:0];
			end
			// A far sample still moves the raster position but gives no point.
			if (d < far)
				points_due = {points_due, project_point(d, c, r)};
		endfunction

		function void check_result(point_t got);
			point_t want;
			if (points_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected point x=%h y=%h z=%h col=%0d row=%0d",
						got.x, got.y, got.z, got.col, got.row);
				return;
			end
			want = points_due.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z
					|| got.col !== want.col || got.row !== want.row) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("point mismatch: expected x=%h y=%h z=%h col=%0d row=%0d",
						want.x, want.y, want.z, want.col, want.row);
					$display("                got      x=%h y=%h z=%h col=%0d row=%0d",
						got.x, got.y, got.z, got.col, got.row);
				end
			end
		endfunction

		function int pending();
			return points_due.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [DEPTH_W-1:0] s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [119:0]       m_tdata;
	logic               wr_en;
	logic [2:0]         wr_index;
	logic [CFG_W-1:0]   wr_data;

	bit no_idle;
	bit long_hold_req;
	int idle_cycles;
	point_scoreboard sb = new();

	depth_to_point_cloud dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(point_t'(m_tdata));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Output side: random hold-offs, plus one long one on request.
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (hold == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
				hold = pick_gap();
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_depth(logic [DEPTH_W-1:0] d);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	task automatic load_setup(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
			logic [CFG_W-1:0] far, logic [CFG_W-1:0] focal, logic [CFG_W-1:0] principal,
			logic [CFG_W-1:0] p0, logic [CFG_W-1:0] p1, logic [CFG_W-1:0] p2);
		cfg_write(REG_IMAGE_WIDTH, w);
		cfg_write(REG_IMAGE_HEIGHT, h);
		cfg_write(REG_FAR_LIMIT, far);
		cfg_write(REG_INV_FOCAL, focal);
		cfg_write(REG_PRINCIPAL_SKEW, principal);
		cfg_write(REG_POSE_ROW0, p0);
		cfg_write(REG_POSE_ROW1, p1);
		cfg_write(REG_POSE_ROW2, p2);
	endtask

	// Stop offering, wait for every point, then let a dropped sample settle.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [DEPTH_W-1:0] rand_depth(logic [DEPTH_W-1:0] far);
		if (far == 0 || $urandom_range(0, 4) == 0)
			return DEPTH_W'($urandom);
		return DEPTH_W'($urandom_range(0, int'(far) - 1));
	endfunction

	function automatic logic [15:0] rand_rot();
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic logic [CFG_W-1:0] rand_pose_row();
		if ($urandom_range(0, 4) == 0)
			return {$urandom, $urandom};
		return {16'($urandom), rand_rot(), rand_rot(), rand_rot()};
	endfunction

	initial begin
		int ph, i, r;
		logic [CFG_W-1:0] w, h, far, focal, principal;
		longint plane;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		wr_en = 1'b0;
		wr_index = REG_IMAGE_WIDTH;
		wr_data = '0;
		no_idle = 1'b0;
		long_hold_req = 1'b0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setup: zero reciprocals and identity pose, a sample equal to far.
		send_depth(24'h000000);
		send_depth(DEPTH_MAX);
		send_depth(DEPTH_MAX - 24'd1);
		send_depth(24'h000001);
		send_depth(24'h800000);
		drain();

		// A zero width acts as one, and samples around the far limit.
		load_setup(64'd0, 64'd3, 64'h80_0000, {32'd8589934, 32'd8589934},
			{16'h0080, 24'd983040, 24'd1310720},
			{16'h0100, 16'h0000, 16'h0400, 16'h3F00},
			{16'hFF00, 16'h0200, 16'h3F80, 16'hFE00},
			{16'h0080, 16'h4000, 16'hFE00, 16'h0000});
		send_depth(24'h7FFFFF);
		send_depth(24'h800000);
		send_depth(24'h800001);
		send_depth(24'h000000);
		send_depth(DEPTH_MAX);
		send_depth(24'h001000);
		send_depth(24'h4A3C5E);
		drain();

		// Full-scale registers drive the camera clamp and the output saturation.
		load_setup(64'd5, 64'd2, CFG_W'(DEPTH_MAX), ALL_ONES, ALL_ONES,
			{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF},
			{16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, ALL_ONES);
		send_depth(DEPTH_MAX - 24'd1);
		send_depth(24'hFFF000);
		send_depth(24'h000001);
		send_depth(24'h000000);
		send_depth(24'h555555);
		send_depth(24'hAAAAAA);
		send_depth(24'h123456);
		drain();

		// Zero reciprocal on x only.
		cfg_write(REG_INV_FOCAL, {32'd0, 32'h00FF_FFFF});
		send_depth(24'h00F000);
		send_depth(24'h3C0000);
		send_depth(24'hFFFFFE);
		drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			r = $urandom_range(0, 9);
			w = CFG_W'((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 4096 : (r == 3) ? 8191 :
				(r == 4) ? 640 : $urandom_range(2, 24));
			r = $urandom_range(0, 9);
			h = CFG_W'((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 4096 :
				$urandom_range(2, 12));
			r = $urandom_range(0, 3);
			if (r == 0) begin
				far = CFG_W'(DEPTH_MAX);
			end else if (r == 1) begin
				plane = longint'($urandom_range(24'h001000, DEPTH_MAX));
				far = (plane * 99) / 100;
			end else begin
				far = CFG_W'($urandom_range(24'h100000, DEPTH_MAX));
			end
			r = $urandom_range(0, 7);
			focal = (r == 0) ? ALL_ONES : (r == 1) ? 64'd0 : (r == 2) ? {$urandom, $urandom} :
				{32'($urandom_range(1 << 22, 1 << 26)), 32'($urandom_range(1 << 22, 1 << 26))};
			r = $urandom_range(0, 7);
			principal = (r == 0) ? ALL_ONES : {$urandom, $urandom};
			if (ph == 1) begin
				w = 64'd640;
				h = 64'd480;
			end
			load_setup(w, h, far, focal, principal, rand_pose_row(), rand_pose_row(),
				rand_pose_row());

			// Phase 0 backs the block up behind a long output hold-off;
			// phase 3 runs with no idling on either side.
			no_idle = (ph == 0 || ph == 3);
			if (ph == 0)
				long_hold_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_depth(rand_depth(sb.far));
			drain();
			no_idle = 1'b0;
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
